// ----- hdl/lpcw_pkg.sv -----
package lpcw_pkg;

   localparam int LED_DEPTH  = 256;
   localparam int LED_IDX_W  = $clog2(LED_DEPTH);
   localparam int HUE_W      = 16;
   localparam int CHAN_W     = 8;
   localparam int COUNT_W    = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int STAGES     = 7;

   localparam logic [CHAN_W-1:0]  CHAN_MAX     = 8'd255;
   localparam logic [CHAN_W-1:0]  BRIGHT_RESET = 8'd255;
   localparam logic [COUNT_W-1:0] COUNT_RESET  = 9'd256;

   localparam logic [15:0] HUE_PERIOD     = 16'd360;
   localparam logic [31:0] HUE_RECIP      = 32'd46604;
   localparam int          HUE_RECIP_SH   = 24;
   localparam logic [18:0] SEC_RECIP      = 19'd1093;
   localparam int          SEC_RECIP_SH   = 16;
   localparam logic [8:0]  SEC_SPAN       = 9'd60;
   localparam logic [9:0]  F_MUL          = 10'd17;
   localparam int          F_SHIFT        = 2;

   localparam logic [CSR_IDX_W-1:0] REG_BRIGHTNESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STRIP_LEN  = 2'd1;

   localparam logic FUNC_RGB = 1'b0;
   localparam logic FUNC_HSV = 1'b1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   localparam logic [2:0] SEC_RED_YEL = 3'd0;
   localparam logic [2:0] SEC_YEL_GRN = 3'd1;
   localparam logic [2:0] SEC_GRN_CYN = 3'd2;
   localparam logic [2:0] SEC_CYN_BLU = 3'd3;
   localparam logic [2:0] SEC_BLU_MAG = 3'd4;

   typedef struct packed {
      logic                 func;
      logic                 ok;
      logic [LED_IDX_W-1:0] idx;
      logic [CHAN_W-1:0]    red;
      logic [CHAN_W-1:0]    green;
      logic [CHAN_W-1:0]    blue;
      logic [HUE_W-1:0]     hue;
      logic [CHAN_W-1:0]    sat;
      logic [CHAN_W-1:0]    level;
   } lpcw_item_type;

   typedef struct packed {
      logic                 ok;
      logic [LED_IDX_W-1:0] idx;
      logic [CHAN_W-1:0]    red;
      logic [CHAN_W-1:0]    green;
      logic [CHAN_W-1:0]    blue;
   } lpcw_pix_type;

   typedef struct packed {
      logic                 status;
      logic [LED_IDX_W-1:0] pixel_index;
      logic [CHAN_W-1:0]    drive_red;
      logic [CHAN_W-1:0]    drive_green;
      logic [CHAN_W-1:0]    drive_blue;
      logic [CHAN_W-1:0]    raw_red;
      logic [CHAN_W-1:0]    raw_green;
      logic [CHAN_W-1:0]    raw_blue;
   } lpcw_rsp_type;

   // Exact floor(x / 255) for every x up to 255 * 255.
   function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
      logic [16:0] sum;
      sum = 17'(x) + 17'(x[15:8]) + 17'd1;
      return sum[15:8];
   endfunction

endpackage

// ----- hdl/lpcw_if.sv -----
interface lpcw_req_if;
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic [lpcw_pkg::HUE_W-1:0]    led_addr;
   logic [lpcw_pkg::CHAN_W-1:0]   red_in;
   logic [lpcw_pkg::CHAN_W-1:0]   green_in;
   logic [lpcw_pkg::CHAN_W-1:0]   blue_in;
   logic [lpcw_pkg::HUE_W-1:0]    hue;
   logic [lpcw_pkg::CHAN_W-1:0]   saturation;
   logic [lpcw_pkg::CHAN_W-1:0]   level;

   modport source(output valid, func, led_addr, red_in, green_in, blue_in, hue,
                  saturation, level, input ready);
   modport sink(input valid, func, led_addr, red_in, green_in, blue_in, hue,
                saturation, level, output ready);
endinterface

interface lpcw_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             status;
   logic [lpcw_pkg::LED_IDX_W-1:0]   pixel_index;
   logic [lpcw_pkg::CHAN_W-1:0]      drive_red;
   logic [lpcw_pkg::CHAN_W-1:0]      drive_green;
   logic [lpcw_pkg::CHAN_W-1:0]      drive_blue;
   logic [lpcw_pkg::CHAN_W-1:0]      raw_red;
   logic [lpcw_pkg::CHAN_W-1:0]      raw_green;
   logic [lpcw_pkg::CHAN_W-1:0]      raw_blue;

   modport source(output valid, status, pixel_index, drive_red, drive_green, drive_blue,
                  raw_red, raw_green, raw_blue, input ready);
   modport sink(input valid, status, pixel_index, drive_red, drive_green, drive_blue,
                raw_red, raw_green, raw_blue, output ready);
endinterface

interface lpcw_csr_if;
   logic                              valid;
   logic                              ready;
   logic [lpcw_pkg::CSR_IDX_W-1:0]    index;
   logic [lpcw_pkg::CSR_DATA_W-1:0]   data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ----- hdl/lpcw_hsv.sv -----
module lpcw_hsv (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  lpcw_pkg::lpcw_item_type in_item,
   output logic                    out_valid,
   input  logic                    out_ready,
   output lpcw_pkg::lpcw_pix_type  out_pix
);
   import lpcw_pkg::*;

   logic [STAGES-1:0] v_ff;
   logic [STAGES-1:0] adv;

   lpcw_item_type c0_ff, c1_ff, c2_ff, c3_ff, c4_ff, c5_ff;
   logic [31:0]       hprod0_ff, hprod0_in;
   logic [15:0]       pn0_ff, pn0_in;
   logic [8:0]        h360_1_ff, h360_1_in, h360_2_ff;
   logic [15:0]       hsub;
   logic [7:0]        qt;
   logic [CHAN_W-1:0] p1_ff, p1_in, p2_ff, p3_ff, p4_ff, p5_ff;
   logic [18:0]       secp2_ff, secp2_in;
   logic [2:0]        sec3_ff, sec3_in, sec4_ff, sec5_ff;
   logic [5:0]        rem;
   logic [9:0]        fm;
   logic [CHAN_W-1:0] f3_ff, f3_in;
   logic [15:0]       fs4_ff, fs4_in, ts4_ff, ts4_in;
   logic [CHAN_W-1:0] xq, xt;
   logic [15:0]       qn5_ff, qn5_in, tn5_ff, tn5_in;
   logic [CHAN_W-1:0] qv, tv, pv, vv;
   lpcw_pix_type      pix6_ff, pix6_in;

   always_comb begin
      adv[STAGES-1] = !v_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[STAGES-1];
   assign out_pix   = pix6_ff;

   always_comb begin
      hprod0_in = 32'(in_item.hue) * HUE_RECIP;
      pn0_in    = 16'(in_item.level) * 16'(CHAN_MAX - in_item.sat);

      qt        = hprod0_ff[HUE_RECIP_SH +: 8];
      hsub      = 16'(16'(qt) * HUE_PERIOD);
      h360_1_in = 9'(c0_ff.hue - hsub);
      p1_in     = div255(pn0_ff);

      secp2_in  = 19'(h360_1_ff) * SEC_RECIP;

      sec3_in   = secp2_ff[SEC_RECIP_SH +: 3];
      rem       = 6'(h360_2_ff - 9'(9'(sec3_in) * SEC_SPAN));
      fm        = 10'(rem) * F_MUL;
      f3_in     = 8'(fm >> F_SHIFT);

      fs4_in    = 16'(f3_ff) * 16'(c3_ff.sat);
      ts4_in    = 16'(CHAN_MAX - f3_ff) * 16'(c3_ff.sat);

      xq        = CHAN_MAX - div255(fs4_ff);
      xt        = CHAN_MAX - div255(ts4_ff);
      qn5_in    = 16'(c4_ff.level) * 16'(xq);
      tn5_in    = 16'(c4_ff.level) * 16'(xt);

      qv = div255(qn5_ff);
      tv = div255(tn5_ff);
      pv = p5_ff;
      vv = c5_ff.level;
      pix6_in.ok  = c5_ff.ok;
      pix6_in.idx = c5_ff.idx;
      if (c5_ff.func == FUNC_RGB) begin
         pix6_in.red   = c5_ff.red;
         pix6_in.green = c5_ff.green;
         pix6_in.blue  = c5_ff.blue;
      end else begin
         unique case (sec5_ff)
            SEC_RED_YEL: begin
               pix6_in.red = vv; pix6_in.green = tv; pix6_in.blue = pv;
            end
            SEC_YEL_GRN: begin
               pix6_in.red = qv; pix6_in.green = vv; pix6_in.blue = pv;
            end
            SEC_GRN_CYN: begin
               pix6_in.red = pv; pix6_in.green = vv; pix6_in.blue = tv;
            end
            SEC_CYN_BLU: begin
               pix6_in.red = pv; pix6_in.green = qv; pix6_in.blue = vv;
            end
            SEC_BLU_MAG: begin
               pix6_in.red = tv; pix6_in.green = pv; pix6_in.blue = vv;
            end
            default: begin
               pix6_in.red = vv; pix6_in.green = pv; pix6_in.blue = qv;
            end
         endcase
      end
      if (!c5_ff.ok) begin
         pix6_in.red   = '0;
         pix6_in.green = '0;
         pix6_in.blue  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         c0_ff     <= in_item;
         hprod0_ff <= hprod0_in;
         pn0_ff    <= pn0_in;
      end
      if (adv[1]) begin
         c1_ff     <= c0_ff;
         h360_1_ff <= h360_1_in;
         p1_ff     <= p1_in;
      end
      if (adv[2]) begin
         c2_ff     <= c1_ff;
         h360_2_ff <= h360_1_ff;
         secp2_ff  <= secp2_in;
         p2_ff     <= p1_ff;
      end
      if (adv[3]) begin
         c3_ff   <= c2_ff;
         sec3_ff <= sec3_in;
         f3_ff   <= f3_in;
         p3_ff   <= p2_ff;
      end
      if (adv[4]) begin
         c4_ff   <= c3_ff;
         sec4_ff <= sec3_ff;
         fs4_ff  <= fs4_in;
         ts4_ff  <= ts4_in;
         p4_ff   <= p3_ff;
      end
      if (adv[5]) begin
         c5_ff   <= c4_ff;
         sec5_ff <= sec4_ff;
         qn5_ff  <= qn5_in;
         tn5_ff  <= tn5_in;
         p5_ff   <= p4_ff;
      end
      if (adv[6]) begin
         pix6_ff <= pix6_in;
      end
   end

endmodule

// ----- hdl/lpcw_store.sv -----
module lpcw_store (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [lpcw_pkg::CHAN_W-1:0]       brightness,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  lpcw_pkg::lpcw_pix_type            in_pix,
   output logic                              out_valid,
   input  logic                              out_ready,
   output lpcw_pkg::lpcw_rsp_type            out_rsp
);
   import lpcw_pkg::*;

   logic [3*CHAN_W-1:0] mem [LED_DEPTH];
   logic [LED_DEPTH-1:0] vld_ff;
   logic [3*CHAN_W-1:0] rdata_ff;
   logic [3*CHAN_W-1:0] wdata;
   logic                 wr_en;
   logic                 load;
   logic                 out_v_ff;
   logic                 status_ff;
   logic [LED_IDX_W-1:0] idx_ff;
   logic [CHAN_W-1:0]    dr_ff, dg_ff, db_ff, dr_in, dg_in, db_in;
   logic [CHAN_W:0]      scale;
   logic [2*CHAN_W:0]    pr, pg, pb;

   assign in_ready = !out_v_ff || out_ready;
   assign load     = in_ready;
   assign wr_en    = load && in_valid && in_pix.ok;
   assign wdata    = {in_pix.red, in_pix.green, in_pix.blue};

   always_comb begin
      scale = 9'(brightness) + 9'd1;
      pr    = 17'(in_pix.red) * 17'(scale);
      pg    = 17'(in_pix.green) * 17'(scale);
      pb    = 17'(in_pix.blue) * 17'(scale);
      dr_in = pr[CHAN_W +: CHAN_W];
      dg_in = pg[CHAN_W +: CHAN_W];
      db_in = pb[CHAN_W +: CHAN_W];
   end

   // The read port returns the beat's own write, so in-range results show what was stored.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[in_pix.idx] <= wdata;
      end
      if (load) begin
         if (!in_pix.ok) begin
            rdata_ff <= '0;
         end else if (wr_en) begin
            rdata_ff <= wdata;
         end else if (vld_ff[in_pix.idx]) begin
            rdata_ff <= mem[in_pix.idx];
         end else begin
            rdata_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         out_v_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[in_pix.idx] <= 1'b1;
         end
         if (load) begin
            out_v_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= in_pix.ok ? STATUS_OK : STATUS_RANGE;
         idx_ff    <= in_pix.idx;
         dr_ff     <= dr_in;
         dg_ff     <= dg_in;
         db_ff     <= db_in;
      end
   end

   assign out_valid           = out_v_ff;
   assign out_rsp.status      = status_ff;
   assign out_rsp.pixel_index = idx_ff;
   assign out_rsp.drive_red   = dr_ff;
   assign out_rsp.drive_green = dg_ff;
   assign out_rsp.drive_blue  = db_ff;
   assign out_rsp.raw_red     = rdata_ff[2*CHAN_W +: CHAN_W];
   assign out_rsp.raw_green   = rdata_ff[CHAN_W +: CHAN_W];
   assign out_rsp.raw_blue    = rdata_ff[0 +: CHAN_W];

endmodule

// ----- hdl/led_pixel_color_writer.sv -----
// Channel    Dir   Beat carries
// req_chan   in    func, led_addr, red_in, green_in, blue_in, hue, saturation, level
// rsp_chan   out   status, pixel_index, drive_red/green/blue, raw_red/green/blue
// csr_chan   in    index (0 brightness, 1 strip length), data
//
// One beat is accepted per cycle while results are not stalled; a result passes through
// the seven conversion stages (hue reduction and sector reciprocal multiplies,
// then the p/q/t products) and then the store's registered read port.
// Reset clears the colour store's valid bits at once; no clearing pass is needed.
// A stalled result holds the output register, and the pipeline keeps filling bubbles
// behind it, so requests are still taken until every stage holds a beat.
module led_pixel_color_writer (
   input  logic      clock,
   input  logic      reset,
   lpcw_req_if.sink  req_chan,
   lpcw_rsp_if.source rsp_chan,
   lpcw_csr_if.sink  csr_chan
);
   import lpcw_pkg::*;

   logic [CHAN_W-1:0]  brightness_ff;
   logic [COUNT_W-1:0] strip_len_ff;
   lpcw_item_type      item;
   logic               idx_ok;
   logic               pix_valid;
   logic               pix_ready;
   lpcw_pix_type       pix;
   lpcw_rsp_type       rsp;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= BRIGHT_RESET;
         strip_len_ff  <= COUNT_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_BRIGHTNESS: brightness_ff <= csr_chan.data[CHAN_W-1:0];
            REG_STRIP_LEN:  strip_len_ff  <= csr_chan.data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      idx_ok     = (req_chan.led_addr < 16'(strip_len_ff)) &&
                   (req_chan.led_addr < 16'(LED_DEPTH));
      item.func  = req_chan.func;
      item.ok    = idx_ok;
      item.idx   = idx_ok ? req_chan.led_addr[LED_IDX_W-1:0] : '0;
      item.red   = req_chan.red_in;
      item.green = req_chan.green_in;
      item.blue  = req_chan.blue_in;
      item.hue   = req_chan.hue;
      item.sat   = req_chan.saturation;
      item.level = req_chan.level;
   end

   lpcw_hsv u_hsv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_item   (item),
      .out_valid (pix_valid),
      .out_ready (pix_ready),
      .out_pix   (pix)
   );

   lpcw_store u_store (
      .clock      (clock),
      .reset      (reset),
      .brightness (brightness_ff),
      .in_valid   (pix_valid),
      .in_ready   (pix_ready),
      .in_pix     (pix),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .out_rsp    (rsp)
   );

   assign rsp_chan.status      = rsp.status;
   assign rsp_chan.pixel_index = rsp.pixel_index;
   assign rsp_chan.drive_red   = rsp.drive_red;
   assign rsp_chan.drive_green = rsp.drive_green;
   assign rsp_chan.drive_blue  = rsp.drive_blue;
   assign rsp_chan.raw_red     = rsp.raw_red;
   assign rsp_chan.raw_green   = rsp.raw_green;
   assign rsp_chan.raw_blue    = rsp.raw_blue;

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == STATUS_RANGE |->
         rsp_chan.pixel_index == '0 && rsp_chan.raw_red == '0 && rsp_chan.raw_green == '0 &&
         rsp_chan.raw_blue == '0 && rsp_chan.drive_red == '0 &&
         rsp_chan.drive_green == '0 && rsp_chan.drive_blue == '0)
      else $error("rejected beat carries nonzero fields");

   a_drive_le_raw: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.drive_red <= rsp_chan.raw_red &&
         rsp_chan.drive_green <= rsp_chan.raw_green && rsp_chan.drive_blue <= rsp_chan.raw_blue)
      else $error("drive value exceeds stored colour");

   a_full_bright: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && brightness_ff == CHAN_MAX |->
         rsp_chan.drive_red == rsp_chan.raw_red && rsp_chan.drive_green == rsp_chan.raw_green &&
         rsp_chan.drive_blue == rsp_chan.raw_blue)
      else $error("full brightness changed the colour");

endmodule

// ----- bench/led_pixel_color_writer_tb.sv -----
module led_pixel_color_writer_tb;
   import lpcw_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_3 = 2'd3;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 80;

   typedef struct packed {
      logic              func;
      logic [HUE_W-1:0]  led_addr;
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
      logic [HUE_W-1:0]  hue;
      logic [CHAN_W-1:0] saturation;
      logic [CHAN_W-1:0] level;
   } pixel_cmd_type;

   class pixel_scoreboard;
      lpcw_rsp_type       pending[$];
      logic [CHAN_W-1:0]  brightness;
      logic [COUNT_W-1:0] strip_len;
      logic [23:0]        colour_store[LED_DEPTH];
      int unsigned        errors;

      function new();
         brightness = BRIGHT_RESET;
         strip_len = COUNT_RESET;
         foreach (colour_store[i]) colour_store[i] = '0;
         errors = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_BRIGHTNESS: brightness = data[CHAN_W-1:0];
            REG_STRIP_LEN: strip_len = data[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [CHAN_W-1:0] dim(logic [CHAN_W-1:0] c);
         return 8'((int'(c) * (int'(brightness) + 1)) >> 8);
      endfunction

      function void hsv_to_rgb(input logic [HUE_W-1:0] hue, input logic [CHAN_W-1:0] sat,
                               input logic [CHAN_W-1:0] val, output logic [CHAN_W-1:0] r,
                               output logic [CHAN_W-1:0] g, output logic [CHAN_W-1:0] b);
         int unsigned h, f, s, v, p, q, t;
         h = int'(hue) % 360;
         s = sat;
         v = val;
         f = (h % 60) * 255 / 60;
         p = v * (255 - s) / 255;
         q = v * (255 - f * s / 255) / 255;
         t = v * (255 - (255 - f) * s / 255) / 255;
         case (3'(h / 60))
            SEC_RED_YEL: {r, g, b} = {8'(v), 8'(t), 8'(p)};
            SEC_YEL_GRN: {r, g, b} = {8'(q), 8'(v), 8'(p)};
            SEC_GRN_CYN: {r, g, b} = {8'(p), 8'(v), 8'(t)};
            SEC_CYN_BLU: {r, g, b} = {8'(p), 8'(q), 8'(v)};
            SEC_BLU_MAG: {r, g, b} = {8'(t), 8'(p), 8'(v)};
            default: {r, g, b} = {8'(v), 8'(p), 8'(q)};
         endcase
      endfunction

      function void note_request(pixel_cmd_type cmd);
         lpcw_rsp_type      want;
         int unsigned       lim;
         logic [CHAN_W-1:0] r, g, b;
         lim = (strip_len < LED_DEPTH) ? strip_len : LED_DEPTH;
         want = '0;
         if (cmd.led_addr >= lim) begin
            want.status = STATUS_RANGE;
         end else begin
            if (cmd.func == FUNC_RGB) begin
               {r, g, b} = {cmd.red_in, cmd.green_in, cmd.blue_in};
            end else begin
               hsv_to_rgb(cmd.hue, cmd.saturation, cmd.level, r, g, b);
            end
            colour_store[cmd.led_addr[LED_IDX_W-1:0]] = {r, g, b};
            want.status = STATUS_OK;
            want.pixel_index = cmd.led_addr[LED_IDX_W-1:0];
            want.drive_red = dim(r);
            want.drive_green = dim(g);
            want.drive_blue = dim(b);
            want.raw_red = r;
            want.raw_green = g;
            want.raw_blue = b;
         end
         pending.push_back(want);
      endfunction

      function void compare(string name, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            $error("Field %s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(lpcw_rsp_type got);
         lpcw_rsp_type want;
         if (pending.size() == 0) begin
            $error("Result beat arrived with no expected result waiting.");
            errors++;
            return;
         end
         want = pending.pop_front();
         compare("status", want.status, got.status);
         compare("pixel_index", want.pixel_index, got.pixel_index);
         compare("drive_red", want.drive_red, got.drive_red);
         compare("drive_green", want.drive_green, got.drive_green);
         compare("drive_blue", want.drive_blue, got.drive_blue);
         compare("raw_red", want.raw_red, got.raw_red);
         compare("raw_green", want.raw_green, got.raw_green);
         compare("raw_blue", want.raw_blue, got.raw_blue);
      endfunction
   endclass

   logic clock;
   logic reset;

   lpcw_req_if req_chan();
   lpcw_rsp_if rsp_chan();
   lpcw_csr_if csr_chan();

   pixel_scoreboard sb = new();
   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   bit hold_request = 1'b0;

   led_pixel_color_writer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // The receiver may be told to hold off for a long stretch so that the pipeline backs up.
   initial begin
      int           hold_left;
      lpcw_rsp_type got;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            got = {rsp_chan.status, rsp_chan.pixel_index, rsp_chan.drive_red,
                   rsp_chan.drive_green, rsp_chan.drive_blue, rsp_chan.raw_red,
                   rsp_chan.raw_green, rsp_chan.raw_blue};
            sb.check_result(got);
         end
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   function automatic pixel_cmd_type make_cmd(logic func, logic [15:0] idx, logic [7:0] r,
                                              logic [7:0] g, logic [7:0] b, logic [15:0] hue,
                                              logic [7:0] sat, logic [7:0] val);
      pixel_cmd_type c;
      c = '{func, idx, r, g, b, hue, sat, val};
      return c;
   endfunction

   function automatic logic [7:0] edgy_byte();
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick == 0) return 8'd0;
      if (pick == 1) return 8'd255;
      return 8'($urandom_range(255));
   endfunction

   function automatic pixel_cmd_type random_cmd();
      pixel_cmd_type c;
      int unsigned   lim, pick;
      lim = (sb.strip_len < LED_DEPTH) ? sb.strip_len : LED_DEPTH;
      pick = $urandom_range(99);
      c.func = 1'($urandom_range(1));
      if (lim > 0 && pick < 75) c.led_addr = 16'($urandom_range(lim - 1));
      else if (pick < 88) c.led_addr = 16'(lim + $urandom_range(2)) - 16'd1;
      else c.led_addr = 16'($urandom_range(16'hFFFF));
      c.red_in = edgy_byte();
      c.green_in = edgy_byte();
      c.blue_in = edgy_byte();
      pick = $urandom_range(9);
      if (pick < 6) c.hue = 16'($urandom_range(359));
      else if (pick < 8) c.hue = 16'(60 * $urandom_range(6)) - 16'($urandom_range(1));
      else c.hue = 16'($urandom_range(16'hFFFF));
      c.saturation = edgy_byte();
      c.level = edgy_byte();
      return c;
   endfunction

   task automatic send_cmd(pixel_cmd_type c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.func <= c.func;
      req_chan.led_addr <= c.led_addr;
      req_chan.red_in <= c.red_in;
      req_chan.green_in <= c.green_in;
      req_chan.blue_in <= c.blue_in;
      req_chan.hue <= c.hue;
      req_chan.saturation <= c.saturation;
      req_chan.level <= c.level;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sb.note_request(c);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data, bit more);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= data;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      sb.write_register(idx, data);
      if (!more) csr_chan.valid <= 1'b0;
   endtask

   task automatic configure(logic [CSR_DATA_W-1:0] bright, logic [CSR_DATA_W-1:0] count);
      csr_write(REG_BRIGHTNESS, bright, 1'b1);
      csr_write(REG_STRIP_LEN, count, 1'b0);
   endtask

   task automatic settle_pipeline();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_segment(int count, int s_idle, int r_idle, bit hold);
      send_idle_pct = s_idle;
      rsp_idle_pct = r_idle;
      if (hold) hold_request = 1'b1;
      repeat (count) send_cmd(random_cmd());
      req_chan.valid <= 1'b0;
      settle_pipeline();
   endtask

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.func <= FUNC_RGB;
      req_chan.led_addr <= '0;
      req_chan.red_in <= '0;
      req_chan.green_in <= '0;
      req_chan.blue_in <= '0;
      req_chan.hue <= '0;
      req_chan.saturation <= '0;
      req_chan.level <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= REG_BRIGHTNESS;
      csr_chan.data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_cmd(make_cmd(FUNC_RGB, 16'd0, 8'h00, 8'h00, 8'h00, 16'd0, 8'd0, 8'd0));
      send_cmd(make_cmd(FUNC_RGB, 16'd255, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF));
      send_cmd(make_cmd(FUNC_RGB, 16'd170, 8'hAA, 8'h55, 8'hAA, 16'd0, 8'd0, 8'd0));
      send_cmd(make_cmd(FUNC_RGB, 16'd85, 8'h55, 8'hAA, 8'h55, 16'd0, 8'd0, 8'd0));
      send_cmd(make_cmd(FUNC_RGB, 16'd256, 8'h12, 8'h34, 8'h56, 16'd0, 8'd0, 8'd0));
      send_cmd(make_cmd(FUNC_RGB, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'd0, 8'd0, 8'd0));
      send_cmd(make_cmd(FUNC_HSV, 16'd1, 8'd0, 8'd0, 8'd0, 16'd0, 8'd255, 8'd255));
      send_cmd(make_cmd(FUNC_HSV, 16'd2, 8'd0, 8'd0, 8'd0, 16'd60, 8'd255, 8'd255));
      send_cmd(make_cmd(FUNC_HSV, 16'd2, 8'd0, 8'd0, 8'd0, 16'd120, 8'd255, 8'd255));
      send_cmd(make_cmd(FUNC_HSV, 16'd2, 8'd0, 8'd0, 8'd0, 16'd180, 8'd255, 8'd255));
      send_cmd(make_cmd(FUNC_HSV, 16'd2, 8'd0, 8'd0, 8'd0, 16'd240, 8'd255, 8'd255));
      send_cmd(make_cmd(FUNC_HSV, 16'd2, 8'd0, 8'd0, 8'd0, 16'd300, 8'd255, 8'd255));
      send_cmd(make_cmd(FUNC_HSV, 16'd2, 8'd0, 8'd0, 8'd0, 16'd359, 8'd255, 8'd255));
      send_cmd(make_cmd(FUNC_HSV, 16'd3, 8'd0, 8'd0, 8'd0, 16'd360, 8'd255, 8'd255));
      send_cmd(make_cmd(FUNC_HSV, 16'd4, 8'd0, 8'd0, 8'd0, 16'hFFFF, 8'd200, 8'd180));
      send_cmd(make_cmd(FUNC_HSV, 16'd5, 8'd0, 8'd0, 8'd0, 16'd59, 8'd128, 8'd200));
      send_cmd(make_cmd(FUNC_HSV, 16'd6, 8'd0, 8'd0, 8'd0, 16'd90, 8'd0, 8'd255));
      send_cmd(make_cmd(FUNC_HSV, 16'd7, 8'd0, 8'd0, 8'd0, 16'd200, 8'd255, 8'd0));
      send_cmd(make_cmd(FUNC_HSV, 16'd300, 8'd0, 8'd0, 8'd0, 16'd30, 8'd255, 8'd255));
      send_cmd(make_cmd(FUNC_HSV, 16'd255, 8'd0, 8'd0, 8'd0, 16'd61, 8'd1, 8'd254));
      send_cmd(make_cmd(FUNC_HSV, 16'd9, 8'd0, 8'd0, 8'd0, 16'hAAAA, 8'h55, 8'hAA));
      req_chan.valid <= 1'b0;
      settle_pipeline();

      configure(9'd0, 9'd1);
      run_segment(300, 27, 65, 1'b0);
      configure(9'd128, 9'd256);
      run_segment(300, 27, 65, 1'b1);
      csr_write(REG_SPARE_2, 9'd0, 1'b1);
      csr_write(REG_SPARE_3, 9'h1FF, 1'b1);
      configure(9'h1FF, 9'h1FF);
      run_segment(300, 65, 27, 1'b0);
      configure(9'd77, 9'd0);
      run_segment(100, 65, 27, 1'b0);
      configure(9'($urandom_range(255)), 9'($urandom_range(300, 1)));
      run_segment(400, 0, 0, 1'b1);
      configure(9'd255, 9'd256);
      run_segment(300, 0, 0, 1'b1);

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- led_pixel_color_writer.f -----
hdl/lpcw_pkg.sv
hdl/lpcw_if.sv
hdl/lpcw_hsv.sv
hdl/lpcw_store.sv
hdl/led_pixel_color_writer.sv
bench/led_pixel_color_writer_tb.sv
